[hdl/gchk_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gchk_pkg - shared types, constants and helpers
// Payload structs, register indexes, reset values, the gear table and the
// functions that derive the per-byte limits and masks from the registers.
// ----------------------------------------------------------------------------
package gchk_pkg;

  localparam int IDX_W = 3;

  localparam logic [IDX_W-1:0] REG_MIN_SIZE  = 3'd0;
  localparam logic [IDX_W-1:0] REG_AVG_SIZE  = 3'd1;
  localparam logic [IDX_W-1:0] REG_MAX_SIZE  = 3'd2;
  localparam logic [IDX_W-1:0] REG_MASK_BITS = 3'd3;
  localparam logic [IDX_W-1:0] REG_SALT_WORD = 3'd4;

  localparam logic [26:0] DEF_MIN_SIZE  = 27'd2048;
  localparam logic [28:0] DEF_AVG_SIZE  = 29'd8192;
  localparam logic [30:0] DEF_MAX_SIZE  = 31'd65536;
  localparam logic [4:0]  DEF_MASK_BITS = 5'd13;
  localparam logic [63:0] DEF_SALT_WORD = 64'd0;

  localparam logic [30:0] LEN_CAP = 31'h4000_0000;
  localparam logic [62:0] SAT63   = {63{1'b1}};

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_t;

  typedef struct packed {
    logic [62:0] chunk_index;
    logic [62:0] chunk_start;
    logic [30:0] chunk_length;
  } out_t;

  // Values the datapath looks at for every byte
  typedef struct packed {
    logic [26:0] min_size;
    logic [28:0] normal_point;
    logic [30:0] cut_limit;
    logic [31:0] strict_mask;
    logic [31:0] loose_mask;
    logic [63:0] salt_word;
  } cfg_t;

  function automatic logic [31:0] ones(input logic [5:0] n);
    if (n >= 6'd32) return 32'hFFFF_FFFF;
    return ~(32'hFFFF_FFFF << n);
  endfunction

  // avg - min(min + ceil(min/2), avg)
  function automatic logic [28:0] normal_of(input logic [26:0] mn, input logic [28:0] av);
    logic [27:0] half;
    logic [28:0] lead;
    half = ({1'b0, mn} + 28'd1) >> 1;
    lead = {2'b00, mn} + {1'b0, half};
    if (lead > av) lead = av;
    return av - lead;
  endfunction

  function automatic logic [30:0] limit_of(input logic [30:0] mx);
    return (mx >= LEN_CAP) ? LEN_CAP : mx;
  endfunction

  function automatic logic [31:0] strict_of(input logic [4:0] mb);
    return ones({1'b0, mb} + 6'd1);
  endfunction

  function automatic logic [31:0] loose_of(input logic [4:0] mb);
    if (mb == 5'd0) return 32'd0;
    return ones({1'b0, mb} - 6'd1);
  endfunction

  localparam logic [31:0] GEAR_TABLE [256] = '{
    32'h5C95C078, 32'h22408989, 32'h2D48A214, 32'h12842087, 32'h530F8AFB, 32'h474536B9,
    32'h2963B4F1, 32'h44CB738B, 32'h4EA7403D, 32'h4D606B6E, 32'h074EC5D3, 32'h3AF39D18,
    32'h726003CA, 32'h37A62A74, 32'h51A2F58E, 32'h7506358E, 32'h5D4AB128, 32'h4D4AE17B,
    32'h41E85924, 32'h470C36F7, 32'h4741CBE1, 32'h01BB7F30, 32'h617C1DE3, 32'h2B0C3A1F,
    32'h50C48F73, 32'h21A82D37, 32'h6095ACE0, 32'h419167A0, 32'h3CAF49B0, 32'h40CEA62D,
    32'h66BC1C66, 32'h545E1DAD, 32'h2BFA77CD, 32'h6E85DA24, 32'h5FB0BDC5, 32'h652CFC29,
    32'h3A0AE1AB, 32'h2837E0F3, 32'h6387B70E, 32'h13176012, 32'h4362C2BB, 32'h66D8F4B1,
    32'h37FCE834, 32'h2C9CD386, 32'h21144296, 32'h627268A8, 32'h650DF537, 32'h2805D579,
    32'h3B21EBBD, 32'h7357ED34, 32'h3F58B583, 32'h7150DDCA, 32'h7362225E, 32'h620A6070,
    32'h2C5EF529, 32'h7B522466, 32'h768B78C0, 32'h4B54E51E, 32'h75FA07E5, 32'h06A35FC6,
    32'h30B71024, 32'h1C8626E1, 32'h296AD578, 32'h28D7BE2E, 32'h1490A05A, 32'h7CEE43BD,
    32'h698B56E3, 32'h09DC0126, 32'h4ED6DF6E, 32'h02C1BFC7, 32'h2A59AD53, 32'h29C0E434,
    32'h7D6C5278, 32'h507940A7, 32'h5EF6BA93, 32'h68B6AF1E, 32'h46537276, 32'h611BC766,
    32'h155C587D, 32'h301BA847, 32'h2CC9DDA7, 32'h0A438E2C, 32'h0A69D514, 32'h744C72D3,
    32'h4F326B9B, 32'h7EF34286, 32'h4A0EF8A7, 32'h6AE06EBE, 32'h669C5372, 32'h12402DCB,
    32'h5FEAE99D, 32'h76C7F4A7, 32'h6ABDB79C, 32'h0DFAA038, 32'h20E2282C, 32'h730ED48B,
    32'h069DAC2F, 32'h168ECF3E, 32'h2610E61F, 32'h2C512C8E, 32'h15FB8C06, 32'h5E62BC76,
    32'h69555135, 32'h0ADB864C, 32'h4268F914, 32'h349AB3AA, 32'h20EDFDB2, 32'h51727981,
    32'h37B4B3D8, 32'h5DD17522, 32'h6B2CBFE4, 32'h5C47CF9F, 32'h30FA1CCD, 32'h23DEDB56,
    32'h13D1F50A, 32'h64EDDEE7, 32'h0820B0F7, 32'h46E07308, 32'h1E2D1DFD, 32'h17B06C32,
    32'h250036D8, 32'h284DBF34, 32'h68292EE0, 32'h362EC87C, 32'h087CB1EB, 32'h76B46720,
    32'h104130DB, 32'h71966387, 32'h482DC43F, 32'h2388EF25, 32'h524144E1, 32'h44BD834E,
    32'h448E7DA3, 32'h3FA6EAF9, 32'h3CDA215C, 32'h3A500CF3, 32'h395CB432, 32'h5195129F,
    32'h43945F87, 32'h51862CA4, 32'h56EA8FF1, 32'h201034DC, 32'h4D328FF5, 32'h7D73A909,
    32'h6234D379, 32'h64CFBF9C, 32'h36F6589A, 32'h0A2CE98A, 32'h5FE4D971, 32'h03BC15C5,
    32'h44021D33, 32'h16C1932B, 32'h37503614, 32'h1ACAF69D, 32'h3F03B779, 32'h49E61A03,
    32'h1F52D7EA, 32'h1C6DDD5C, 32'h062218CE, 32'h07E7A11A, 32'h1905757A, 32'h7CE00A53,
    32'h49F44F29, 32'h4BCC70B5, 32'h39FEEA55, 32'h5242CEE8, 32'h3CE56B85, 32'h00B81672,
    32'h46BEECCC, 32'h3CA0AD56, 32'h2396CEE8, 32'h78547F40, 32'h6B08089B, 32'h66A56751,
    32'h781E7E46, 32'h1E2CF856, 32'h3BC13591, 32'h494A4202, 32'h520494D7, 32'h2D87459A,
    32'h757555B6, 32'h42284CC1, 32'h1F478507, 32'h75C95DFF, 32'h35FF8DD7, 32'h4E4757ED,
    32'h2E11F88C, 32'h5E1B5048, 32'h420E6699, 32'h226B0695, 32'h4D1679B4, 32'h5A22646F,
    32'h161D1131, 32'h125C68D9, 32'h1313E32E, 32'h4AA85724, 32'h21DC7EC1, 32'h4FFA29FE,
    32'h72968382, 32'h1CA8EEF3, 32'h3F3B1C28, 32'h39C2FB6C, 32'h6D76493F, 32'h7A22A62E,
    32'h789B1C2A, 32'h16E0CB53, 32'h7DECEEEB, 32'h0DC7E1C6, 32'h5C75BF3D, 32'h52218333,
    32'h106DE4D6, 32'h7DC64422, 32'h65590FF4, 32'h2C02EC30, 32'h64A9AC67, 32'h59CAB2E9,
    32'h4A21D2F3, 32'h0F616E57, 32'h23B54EE8, 32'h02730AAA, 32'h2F3C634D, 32'h7117FC6C,
    32'h01AC6F05, 32'h5A9ED20C, 32'h158C4E2A, 32'h42B699F0, 32'h0C7C14B3, 32'h02BD9641,
    32'h15AD56FC, 32'h1C722F60, 32'h7DA1AF91, 32'h23E0DBCB, 32'h0E93E12B, 32'h64B2791D,
    32'h440D2476, 32'h588EA8DD, 32'h4665A658, 32'h7446C418, 32'h1877A774, 32'h5626407E,
    32'h7F63BD46, 32'h32D2DBD8, 32'h3C790F4A, 32'h772B7239, 32'h6F8B2826, 32'h677FF609,
    32'h0DC82C11, 32'h23FFE354, 32'h2EAC53A6, 32'h16139E09, 32'h0AFD0DBC, 32'h2A4D4237,
    32'h56A368C7, 32'h234325E4, 32'h2DCE9187, 32'h32E8EA7E
  };

endpackage

[hdl/gchk_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gchk_cfg - configuration registers
// Holds the five registers and registers the derived normal point, cut
// limit and masks together with them, so the byte path sees plain values.
// ----------------------------------------------------------------------------
module gchk_cfg import gchk_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [63:0]      cfg_data,
  output cfg_t             cfg
);

  logic [26:0] min_size, min_size_next;
  logic [28:0] avg_size, avg_size_next;
  logic [30:0] max_size, max_size_next;
  logic [4:0]  mask_bits, mask_bits_next;
  logic [63:0] salt_word, salt_word_next;
  cfg_t        derived_next;

  assign cfg_ready = 1'b1;

  always_comb begin
    min_size_next  = min_size;
    avg_size_next  = avg_size;
    max_size_next  = max_size;
    mask_bits_next = mask_bits;
    salt_word_next = salt_word;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_MIN_SIZE:  min_size_next  = cfg_data[26:0];
        REG_AVG_SIZE:  avg_size_next  = cfg_data[28:0];
        REG_MAX_SIZE:  max_size_next  = cfg_data[30:0];
        REG_MASK_BITS: mask_bits_next = cfg_data[4:0];
        REG_SALT_WORD: salt_word_next = cfg_data;
        default: ;
      endcase
    end
    derived_next.min_size     = min_size_next;
    derived_next.normal_point = normal_of(min_size_next, avg_size_next);
    derived_next.cut_limit    = limit_of(max_size_next);
    derived_next.strict_mask  = strict_of(mask_bits_next);
    derived_next.loose_mask   = loose_of(mask_bits_next);
    derived_next.salt_word    = salt_word_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_size           <= DEF_MIN_SIZE;
      avg_size           <= DEF_AVG_SIZE;
      max_size           <= DEF_MAX_SIZE;
      mask_bits          <= DEF_MASK_BITS;
      salt_word          <= DEF_SALT_WORD;
      cfg.min_size       <= DEF_MIN_SIZE;
      cfg.normal_point   <= normal_of(DEF_MIN_SIZE, DEF_AVG_SIZE);
      cfg.cut_limit      <= limit_of(DEF_MAX_SIZE);
      cfg.strict_mask    <= strict_of(DEF_MASK_BITS);
      cfg.loose_mask     <= loose_of(DEF_MASK_BITS);
      cfg.salt_word      <= DEF_SALT_WORD;
    end else begin
      min_size  <= min_size_next;
      avg_size  <= avg_size_next;
      max_size  <= max_size_next;
      mask_bits <= mask_bits_next;
      salt_word <= salt_word_next;
      cfg       <= derived_next;
    end
  end

endmodule

[hdl/gchk_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gchk_core - per-byte hash and cut decision
// Holds the chunk state and, for the byte in the input register, updates
// the gear hash, decides on a cut and forms the chunk descriptor.
// ----------------------------------------------------------------------------
module gchk_core import gchk_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic fire,
  input  in_t  item,
  output logic cut,
  output out_t result
);

  logic [31:0] gear_hash;
  logic [29:0] chunk_position;
  logic [2:0]  salt_phase;
  logic [62:0] chunk_count;
  logic [62:0] stream_total;

  logic [30:0] len;
  logic        hashed;
  logic [7:0]  salt;
  logic [31:0] hash_upd;
  logic [31:0] mask;
  logic [62:0] count_inc;
  logic [63:0] total_sum;
  logic [62:0] total_sat;

  always_comb begin
    len      = {1'b0, chunk_position} + 31'd1;
    hashed   = chunk_position >= {3'b000, cfg.min_size};
    salt     = cfg.salt_word[{salt_phase, 3'b000} +: 8];
    hash_upd = (gear_hash >> 1) + GEAR_TABLE[item.data_byte ^ salt];
    mask     = (chunk_position < {1'b0, cfg.normal_point}) ? cfg.strict_mask
                                                           : cfg.loose_mask;
    cut      = (hashed && ((hash_upd & mask) == 32'd0)) ||
               (len >= cfg.cut_limit) || item.end_of_stream;

    count_inc = (chunk_count == SAT63) ? SAT63 : chunk_count + 63'd1;
    total_sum = {1'b0, stream_total} + {33'd0, len};
    total_sat = total_sum[63] ? SAT63 : total_sum[62:0];

    result.chunk_index  = chunk_count;
    result.chunk_start  = stream_total;
    result.chunk_length = len;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gear_hash      <= '0;
      chunk_position <= '0;
      salt_phase     <= '0;
      chunk_count    <= '0;
      stream_total   <= '0;
    end else if (fire) begin
      if (cut) begin
        gear_hash      <= '0;
        chunk_position <= '0;
        salt_phase     <= total_sat[2:0];
        chunk_count    <= count_inc;
        stream_total   <= total_sat;
      end else begin
        // length stays below the cap here, so it fits the position width
        chunk_position <= len[29:0];
        if (hashed) begin
          gear_hash  <= hash_upd;
          salt_phase <= salt_phase + 3'd1;
        end
      end
    end
  end

endmodule

[hdl/gear_hash_content_chunker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gear_hash_content_chunker - content-defined chunk boundary finder
// Gear-hash chunker: one stream byte in, one chunk descriptor per cut out.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one byte per transaction with an end-of-stream flag; a
//           transaction completes when in_valid is high and in_stall low.
//   out_* : one descriptor (index, start offset, length) per finished chunk,
//           same valid/stall rule; most bytes give no descriptor.
//   cfg_* : register writes, always ready; write only while the block idles.
// Throughput: one byte per cycle when out_stall does not hold a descriptor.
//   The limit is the hash recurrence, one table lookup, shift-add and mask
//   test per cycle in the core.
// Registers: input register for the byte, output register for its descriptor.
// Stall: while a descriptor waits under out_stall the core halts and the
//   input register holds its byte; in_stall rises only when that register
//   is full, so one byte is still taken while the output waits.
// Reset: clears both registers' valid flags and the chunk state and loads
//   the default configuration. No clearing pass is needed.
// ----------------------------------------------------------------------------
module gear_hash_content_chunker import gchk_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_t              in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_t             out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [63:0]      cfg_data
);

  cfg_t cfg;
  logic in_full;
  in_t  in_item;
  logic advance;
  logic fire;
  logic cut;
  out_t result;

  gchk_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  gchk_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .fire   (fire),
    .item   (in_item),
    .cut    (cut),
    .result (result)
  );

  assign advance  = !out_valid || !out_stall;
  assign fire     = in_full && advance;
  assign in_stall = in_full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_item <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= fire && cut;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && cut) begin
      out_data <= result;
    end
  end

  // a descriptor always covers at least one byte and never exceeds the cap
  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.chunk_length != 31'd0))
    else $error("chunk descriptor with zero length");

  a_len_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.chunk_length <= LEN_CAP))
    else $error("chunk length beyond cap");

  // a waiting descriptor must freeze the byte held in the input register
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    (in_full && out_valid && out_stall) |=> (in_full && $stable(in_item)))
    else $error("input byte lost while output stalled");

  // the core only steps when the output register can take its result
  a_fire_slot: assert property (@(posedge clk) disable iff (rst)
    (fire && cut) |=> (out_valid && (out_data == $past(result))))
    else $error("cut descriptor not captured");

endmodule

[dv/gear_hash_content_chunker_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gear_hash_content_chunker_test - self-checking bench for the chunker
// A short directed script of bytes and register writes, then random phases,
// each with fresh register settings and a random byte stream. Each chunk
// descriptor is checked against a bit-exact gear hash chunker model kept
// here or the value typed into the script. Input idles, output stalls at random.
// ----------------------------------------------------------------------------
module gear_hash_content_chunker_test;
  import gchk_pkg::*;

  localparam int RANDOM_BYTES  = 1650;
  localparam int SETTLE_CYCLES = 4;   // input and output registers plus margin
  localparam int DRAIN_CYCLES  = 8;
  localparam int WATCHDOG      = 2000;
  localparam logic [30:0] CHUNK_CAP = 31'h4000_0000;
  localparam logic [62:0] COUNT_SAT = {63{1'b1}};

  localparam logic [31:0] GEAR_LUT [256] = '{
    32'h5C95C078, 32'h22408989, 32'h2D48A214, 32'h12842087, 32'h530F8AFB, 32'h474536B9,
    32'h2963B4F1, 32'h44CB738B, 32'h4EA7403D, 32'h4D606B6E, 32'h074EC5D3, 32'h3AF39D18,
    32'h726003CA, 32'h37A62A74, 32'h51A2F58E, 32'h7506358E, 32'h5D4AB128, 32'h4D4AE17B,
    32'h41E85924, 32'h470C36F7, 32'h4741CBE1, 32'h01BB7F30, 32'h617C1DE3, 32'h2B0C3A1F,
    32'h50C48F73, 32'h21A82D37, 32'h6095ACE0, 32'h419167A0, 32'h3CAF49B0, 32'h40CEA62D,
    32'h66BC1C66, 32'h545E1DAD, 32'h2BFA77CD, 32'h6E85DA24, 32'h5FB0BDC5, 32'h652CFC29,
    32'h3A0AE1AB, 32'h2837E0F3, 32'h6387B70E, 32'h13176012, 32'h4362C2BB, 32'h66D8F4B1,
    32'h37FCE834, 32'h2C9CD386, 32'h21144296, 32'h627268A8, 32'h650DF537, 32'h2805D579,
    32'h3B21EBBD, 32'h7357ED34, 32'h3F58B583, 32'h7150DDCA, 32'h7362225E, 32'h620A6070,
    32'h2C5EF529, 32'h7B522466, 32'h768B78C0, 32'h4B54E51E, 32'h75FA07E5, 32'h06A35FC6,
    32'h30B71024, 32'h1C8626E1, 32'h296AD578, 32'h28D7BE2E, 32'h1490A05A, 32'h7CEE43BD,
    32'h698B56E3, 32'h09DC0126, 32'h4ED6DF6E, 32'h02C1BFC7, 32'h2A59AD53, 32'h29C0E434,
    32'h7D6C5278, 32'h507940A7, 32'h5EF6BA93, 32'h68B6AF1E, 32'h46537276, 32'h611BC766,
    32'h155C587D, 32'h301BA847, 32'h2CC9DDA7, 32'h0A438E2C, 32'h0A69D514, 32'h744C72D3,
    32'h4F326B9B, 32'h7EF34286, 32'h4A0EF8A7, 32'h6AE06EBE, 32'h669C5372, 32'h12402DCB,
    32'h5FEAE99D, 32'h76C7F4A7, 32'h6ABDB79C, 32'h0DFAA038, 32'h20E2282C, 32'h730ED48B,
    32'h069DAC2F, 32'h168ECF3E, 32'h2610E61F, 32'h2C512C8E, 32'h15FB8C06, 32'h5E62BC76,
    32'h69555135, 32'h0ADB864C, 32'h4268F914, 32'h349AB3AA, 32'h20EDFDB2, 32'h51727981,
    32'h37B4B3D8, 32'h5DD17522, 32'h6B2CBFE4, 32'h5C47CF9F, 32'h30FA1CCD, 32'h23DEDB56,
    32'h13D1F50A, 32'h64EDDEE7, 32'h0820B0F7, 32'h46E07308, 32'h1E2D1DFD, 32'h17B06C32,
    32'h250036D8, 32'h284DBF34, 32'h68292EE0, 32'h362EC87C, 32'h087CB1EB, 32'h76B46720,
    32'h104130DB, 32'h71966387, 32'h482DC43F, 32'h2388EF25, 32'h524144E1, 32'h44BD834E,
    32'h448E7DA3, 32'h3FA6EAF9, 32'h3CDA215C, 32'h3A500CF3, 32'h395CB432, 32'h5195129F,
    32'h43945F87, 32'h51862CA4, 32'h56EA8FF1, 32'h201034DC, 32'h4D328FF5, 32'h7D73A909,
    32'h6234D379, 32'h64CFBF9C, 32'h36F6589A, 32'h0A2CE98A, 32'h5FE4D971, 32'h03BC15C5,
    32'h44021D33, 32'h16C1932B, 32'h37503614, 32'h1ACAF69D, 32'h3F03B779, 32'h49E61A03,
    32'h1F52D7EA, 32'h1C6DDD5C, 32'h062218CE, 32'h07E7A11A, 32'h1905757A, 32'h7CE00A53,
    32'h49F44F29, 32'h4BCC70B5, 32'h39FEEA55, 32'h5242CEE8, 32'h3CE56B85, 32'h00B81672,
    32'h46BEECCC, 32'h3CA0AD56, 32'h2396CEE8, 32'h78547F40, 32'h6B08089B, 32'h66A56751,
    32'h781E7E46, 32'h1E2CF856, 32'h3BC13591, 32'h494A4202, 32'h520494D7, 32'h2D87459A,
    32'h757555B6, 32'h42284CC1, 32'h1F478507, 32'h75C95DFF, 32'h35FF8DD7, 32'h4E4757ED,
    32'h2E11F88C, 32'h5E1B5048, 32'h420E6699, 32'h226B0695, 32'h4D1679B4, 32'h5A22646F,
    32'h161D1131, 32'h125C68D9, 32'h1313E32E, 32'h4AA85724, 32'h21DC7EC1, 32'h4FFA29FE,
    32'h72968382, 32'h1CA8EEF3, 32'h3F3B1C28, 32'h39C2FB6C, 32'h6D76493F, 32'h7A22A62E,
    32'h789B1C2A, 32'h16E0CB53, 32'h7DECEEEB, 32'h0DC7E1C6, 32'h5C75BF3D, 32'h52218333,
    32'h106DE4D6, 32'h7DC64422, 32'h65590FF4, 32'h2C02EC30, 32'h64A9AC67, 32'h59CAB2E9,
    32'h4A21D2F3, 32'h0F616E57, 32'h23B54EE8, 32'h02730AAA, 32'h2F3C634D, 32'h7117FC6C,
    32'h01AC6F05, 32'h5A9ED20C, 32'h158C4E2A, 32'h42B699F0, 32'h0C7C14B3, 32'h02BD9641,
    32'h15AD56FC, 32'h1C722F60, 32'h7DA1AF91, 32'h23E0DBCB, 32'h0E93E12B, 32'h64B2791D,
    32'h440D2476, 32'h588EA8DD, 32'h4665A658, 32'h7446C418, 32'h1877A774, 32'h5626407E,
    32'h7F63BD46, 32'h32D2DBD8, 32'h3C790F4A, 32'h772B7239, 32'h6F8B2826, 32'h677FF609,
    32'h0DC82C11, 32'h23FFE354, 32'h2EAC53A6, 32'h16139E09, 32'h0AFD0DBC, 32'h2A4D4237,
    32'h56A368C7, 32'h234325E4, 32'h2DCE9187, 32'h32E8EA7E
  };

  typedef enum logic {ROW_BYTE, ROW_WRITE} row_kind_t;

  typedef struct {
    logic [IDX_W-1:0] idx;
    logic [63:0]      val;
  } reg_write_t;

  typedef struct {
    row_kind_t  kind;
    reg_write_t wr;
    in_t        stim;
    bit         typed;
    out_t       chunk;
  } script_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  in_t              in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_t             out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [63:0]      cfg_data = '0;

  // model registers and chunk state
  logic [26:0] m_min_size  = 27'd2048;
  logic [28:0] m_avg_size  = 29'd8192;
  logic [30:0] m_max_size  = 31'd65536;
  logic [4:0]  m_mask_bits = 5'd13;
  logic [63:0] m_salt      = 64'd0;
  logic [31:0] m_hash      = '0;
  logic [29:0] m_pos       = '0;
  logic [2:0]  m_phase     = '0;
  logic [62:0] m_count     = '0;
  logic [62:0] m_base      = '0;

  out_t        chunks_due [$];
  reg_write_t  writes_due [$];
  script_row_t script [$];

  int errors = 0;
  int random_sent = 0;
  int stall_left = 0;
  int quiet_cycles = 0;
  bit no_idle = 1'b0;
  out_t head;

  gear_hash_content_chunker dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic flag(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  function automatic void apply_reg(input reg_write_t w);
    case (w.idx)
      REG_MIN_SIZE:  m_min_size  = w.val[26:0];
      REG_AVG_SIZE:  m_avg_size  = w.val[28:0];
      REG_MAX_SIZE:  m_max_size  = w.val[30:0];
      REG_MASK_BITS: m_mask_bits = w.val[4:0];
      REG_SALT_WORD: m_salt      = w.val;
      default: ;
    endcase
  endfunction

  // One byte through the chunker; returns 1 with the descriptor on a cut.
  function automatic bit step_chunker(input in_t b, output out_t res);
    logic [31:0] lead, normal, mask;
    logic [30:0] len;
    logic [63:0] sum;
    logic [7:0]  salt;
    int          nbits;
    bit          cut;
    cut = 1'b0;
    res = '0;
    len = {1'b0, m_pos} + 31'd1;
    if (32'(m_pos) >= 32'(m_min_size)) begin
      lead = 32'(m_min_size) + (32'(m_min_size) + 32'd1) / 32'd2;
      if (lead > 32'(m_avg_size)) lead = 32'(m_avg_size);
      normal = 32'(m_avg_size) - lead;
      // strict mask before the normal point, loose after; loose of zero bits is empty
      nbits = (32'(m_pos) < normal) ? int'(m_mask_bits) + 1 : int'(m_mask_bits) - 1;
      mask = (nbits < 0) ? 32'd0 : 32'((64'd1 << nbits) - 64'd1);
      salt = m_salt[8*m_phase +: 8];
      m_phase = m_phase + 3'd1;
      m_hash = (m_hash >> 1) + GEAR_LUT[b.data_byte ^ salt];
      if ((m_hash & mask) == 32'd0) cut = 1'b1;
    end
    if (len >= m_max_size || len >= CHUNK_CAP || b.end_of_stream) cut = 1'b1;
    if (!cut) begin
      m_pos = len[29:0];
      return 1'b0;
    end
    res.chunk_index  = m_count;
    res.chunk_start  = m_base;
    res.chunk_length = len;
    if (m_count != COUNT_SAT) m_count = m_count + 63'd1;
    sum = {1'b0, m_base} + 64'(len);
    m_base = (sum > {1'b0, COUNT_SAT}) ? COUNT_SAT : sum[62:0];
    m_hash = '0;
    m_pos = '0;
    m_phase = m_base[2:0];
    return 1'b1;
  endfunction

  function automatic void add_write(input logic [IDX_W-1:0] idx, input logic [63:0] val);
    script_row_t r;
    r.kind  = ROW_WRITE;
    r.wr    = '{idx: idx, val: val};
    r.stim  = '0;
    r.typed = 1'b0;
    r.chunk = '0;
    script.push_back(r);
  endfunction

  function automatic void add_byte(input logic [7:0] b, input logic eos);
    script_row_t r;
    r.kind  = ROW_BYTE;
    r.wr    = '{idx: '0, val: '0};
    r.stim  = '{data_byte: b, end_of_stream: eos};
    r.typed = 1'b0;
    r.chunk = '0;
    script.push_back(r);
  endfunction

  function automatic void add_cut(input logic [7:0] b, input logic eos, input logic [62:0] idx,
                                  input logic [62:0] start, input logic [30:0] len);
    add_byte(b, eos);
    script[$].typed = 1'b1;
    script[$].chunk = '{chunk_index: idx, chunk_start: start, chunk_length: len};
  endfunction

  // random junk above the register width must be ignored
  function automatic void queue_write(input logic [IDX_W-1:0] idx, input logic [63:0] val);
    int w;
    case (idx)
      REG_MIN_SIZE:  w = 27;
      REG_AVG_SIZE:  w = 29;
      REG_MAX_SIZE:  w = 31;
      REG_MASK_BITS: w = 5;
      default:       w = 64;
    endcase
    if (w < 64 && $urandom_range(0, 3) == 0) val = val | ({$urandom, $urandom} << w);
    writes_due.push_back('{idx: idx, val: val});
  endfunction

  // Block is idle once nothing is due and the pipeline has had time to empty.
  task automatic settle();
    in_valid <= 1'b0;
    while (chunks_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic flush_writes();
    if (writes_due.size() == 0) return;
    cfg_valid <= 1'b1;
    cfg_index <= writes_due[0].idx;
    cfg_data  <= writes_due[0].val;
    while (writes_due.size() != 0) begin
      @(posedge clk);
      if (cfg_ready) begin
        apply_reg(writes_due.pop_front());
        if (writes_due.size() == 0) begin
          cfg_valid <= 1'b0;
        end else begin
          cfg_index <= writes_due[0].idx;
          cfg_data  <= writes_due[0].val;
        end
      end
    end
  endtask

  task automatic send_byte(input in_t b, input bit typed, input out_t typed_chunk);
    int   gap;
    out_t res;
    bit   cut;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    cut = step_chunker(b, res);
    if (typed) chunks_due.push_back(typed_chunk);
    else if (cut) chunks_due.push_back(res);
  endtask

  // descriptor checker and random receive stall
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (chunks_due.size() == 0) begin
          flag($sformatf("unexpected chunk index %0d", out_data.chunk_index));
        end else begin
          head = chunks_due.pop_front();
          if (out_data.chunk_index !== head.chunk_index)
            flag($sformatf("chunk_index got %0d exp %0d", out_data.chunk_index,
                           head.chunk_index));
          if (out_data.chunk_start !== head.chunk_start)
            flag($sformatf("chunk_start got %0d exp %0d (index %0d)", out_data.chunk_start,
                           head.chunk_start, head.chunk_index));
          if (out_data.chunk_length !== head.chunk_length)
            flag($sformatf("chunk_length got %0d exp %0d (index %0d)", out_data.chunk_length,
                           head.chunk_length, head.chunk_index));
        end
        stall_left = no_idle ? 0 : $urandom_range(0, 6);
      end else if (stall_left > 0) begin
        stall_left = stall_left - 1;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 6);
      end
      out_stall <= (stall_left != 0);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG) begin
      $display("[gear_hash_content_chunker] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    in_t b;
    int  pick;
    int  mn, av, mx, mb;
    int  sel;
    logic [63:0] salt;

    // defaults: nothing hashed yet, cuts come from end of stream only
    add_cut(8'h00, 1'b1, 63'd0, 63'd0, 31'd1);
    add_cut(8'hFF, 1'b1, 63'd1, 63'd1, 31'd1);
    add_byte(8'hA5, 1'b0);
    // zero max_size, written with a chunk open: next byte cuts
    add_write(REG_MAX_SIZE, 64'd0);
    add_cut(8'h5A, 1'b0, 63'd2, 63'd2, 31'd2);
    add_cut(8'hFF, 1'b0, 63'd3, 63'd4, 31'd1);
    add_write(REG_MAX_SIZE, 64'd1);
    add_cut(8'h80, 1'b0, 63'd4, 63'd5, 31'd1);
    // empty loose mask from the first byte: every hashed byte cuts
    add_write(REG_MIN_SIZE, 64'd0);
    add_write(REG_AVG_SIZE, 64'd0);
    add_write(REG_MASK_BITS, 64'd0);
    add_write(REG_MAX_SIZE, 64'd1024);
    add_cut(8'h12, 1'b0, 63'd5, 63'd6, 31'd1);
    add_cut(8'hED, 1'b0, 63'd6, 63'd7, 31'd1);
    // all-ones strict mask, full salt
    add_write(REG_MASK_BITS, 64'd31);
    add_write(REG_AVG_SIZE, 64'h1FFF_FFFF);
    add_write(REG_SALT_WORD, 64'hFFFF_FFFF_FFFF_FFFF);
    add_write(REG_MAX_SIZE, 64'd4);
    add_byte(8'h01, 1'b0);
    add_byte(8'h02, 1'b0);
    add_byte(8'h40, 1'b0);
    add_byte(8'h7F, 1'b0);
    // min far above max: forced cut, nothing hashed
    add_write(REG_MIN_SIZE, 64'h7FF_FFFF);
    add_write(REG_MAX_SIZE, 64'd3);
    add_write(REG_MASK_BITS, 64'd8);
    add_write(REG_AVG_SIZE, 64'd256);
    add_write(REG_SALT_WORD, 64'h0123_4567_89AB_CDEF);
    add_byte(8'hAA, 1'b0);
    add_byte(8'h55, 1'b0);
    add_byte(8'hC3, 1'b0);
    add_write(REG_MIN_SIZE, 64'd64);
    add_write(REG_MAX_SIZE, 64'h7FFF_FFFF);
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h3C, 1'b1);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      if (script[i].kind == ROW_WRITE) begin
        writes_due.push_back(script[i].wr);
      end else begin
        if (writes_due.size() != 0) begin
          settle();
          flush_writes();
        end
        send_byte(script[i].stim, script[i].typed, script[i].chunk);
      end
    end

    while (random_sent < RANDOM_BYTES) begin
      settle();
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        mn = 27'h7FF_FFFF; av = 29'h1FFF_FFFF; mx = 31'h7FFF_FFFF; mb = 31;
      end else if (pick == 1) begin
        mn = 0; av = 0; mx = $urandom_range(0, 1); mb = 0;
      end else begin
        mn = $urandom_range(0, 48);
        av = mn + $urandom_range(0, 96);
        mx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, mn + 1)
                                         : av + $urandom_range(1, 200);
        mb = ($urandom_range(0, 4) == 0) ? $urandom_range(11, 31) : $urandom_range(0, 10);
      end
      sel = $urandom_range(0, 3);
      salt = (sel == 0) ? 64'd0 : (sel == 1) ? '1 : {$urandom, $urandom};
      queue_write(REG_MIN_SIZE, 64'(mn));
      queue_write(REG_AVG_SIZE, 64'(av));
      queue_write(REG_MAX_SIZE, 64'(mx));
      queue_write(REG_MASK_BITS, 64'(mb));
      if ($urandom_range(0, 4) != 0) queue_write(REG_SALT_WORD, salt);
      flush_writes();
      no_idle = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(40, 160)) begin
        sel = $urandom_range(0, 9);
        b.data_byte = (sel == 0) ? 8'h00 : (sel == 1) ? 8'hFF : 8'($urandom);
        b.end_of_stream = ($urandom_range(0, 63) == 0);
        send_byte(b, 1'b0, '0);
        random_sent++;
      end
    end

    no_idle = 1'b0;
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("[gear_hash_content_chunker] OK");
    else
      $display("[gear_hash_content_chunker] ERROR");
    $finish;
  end

endmodule

[gear_hash_content_chunker.f]
hdl/gchk_pkg.sv
hdl/gchk_cfg.sv
hdl/gchk_core.sv
hdl/gear_hash_content_chunker.sv
dv/gear_hash_content_chunker_test.sv
